[design/heartbeat_node_monitor_top_assert.svh]
// Assertion macros for the heartbeat node monitor checker.
`ifndef HEARTBEAT_NODE_MONITOR_TOP_ASSERT_SVH
`define HEARTBEAT_NODE_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define HBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define HBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hbm_pkg.sv]
// Package for the heartbeat node monitor: constants, codes and word types.
`default_nettype none
package hbm_pkg;

    localparam int NUM_NODES   = 15;
    localparam int IDX_W       = 4;
    localparam int STATE_W     = 7;
    localparam int TIMER_W     = 16;
    localparam int ALARM_W     = 3;

    localparam logic [STATE_W-1:0] STATE_PREOP = 7'd127;
    localparam logic [STATE_W-1:0] STATE_OPER  = 7'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_NODES - 1);

    // Commands
    localparam logic [2:0] CMD_HEARTBEAT  = 3'd0;
    localparam logic [2:0] CMD_TICK       = 3'd1;
    localparam logic [2:0] CMD_READY      = 3'd2;
    localparam logic [2:0] CMD_OPER       = 3'd3;
    localparam logic [2:0] CMD_CLEAR_BOOT = 3'd4;
    localparam logic [2:0] CMD_RESET_ALL  = 3'd5;

    // Alarm codes
    localparam logic [ALARM_W-1:0] ALM_OK        = 3'd0;
    localparam logic [ALARM_W-1:0] ALM_BOOT      = 3'd1;
    localparam logic [ALARM_W-1:0] ALM_NOT_READY = 3'd2;
    localparam logic [ALARM_W-1:0] ALM_NOT_OPER  = 3'd3;
    localparam logic [ALARM_W-1:0] ALM_TIMEOUT   = 3'd4;

    // Register indexes (paddr[2])
    localparam logic REG_GUARD_RELOAD = 1'b0;
    localparam logic REG_FIRST_NODE   = 1'b1;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] node_nibble;
        logic [7:0] heartbeat_byte;
    } t_in_word;

    typedef struct packed {
        logic       all_good;
        logic [2:0] alarm_code;
        logic [3:0] alarm_node;
    } t_out_word;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic               booted;
        logic [ALARM_W-1:0] alarm;
    } t_entry;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_idx;
        logic               wr_a_en;
        logic               wr_b_en;
        logic [IDX_W-1:0]   wr_idx;
        t_entry             wr_a;
        logic [TIMER_W-1:0] wr_b;
        logic               clr_a;
    } t_tbl_req;

    typedef struct packed {
        t_entry             a;
        logic [TIMER_W-1:0] b;
    } t_tbl_rd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

[design/hbm_table.sv]
// Node table: entry memory and guard timer memory with per-entry valid bits.
`default_nettype none
module hbm_table
    import hbm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_tbl_req i_req,
    output t_tbl_rd       o_rd
);

    t_entry             r_mem_a [0:NUM_NODES-1];
    logic [TIMER_W-1:0] r_mem_b [0:NUM_NODES-1];
    logic [NUM_NODES-1:0] r_va;
    logic [NUM_NODES-1:0] r_vb;

    t_entry             r_rd_a;
    logic [TIMER_W-1:0] r_rd_b;
    logic               r_rd_va;
    logic               r_rd_vb;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_a_en) begin
            r_mem_a[i_req.wr_idx] <= i_req.wr_a;
        end
        if (i_req.wr_b_en) begin
            r_mem_b[i_req.wr_idx] <= i_req.wr_b;
        end
        if (i_req.rd_en) begin
            r_rd_a  <= r_mem_a[i_req.rd_idx];
            r_rd_b  <= r_mem_b[i_req.rd_idx];
            r_rd_va <= r_va[i_req.rd_idx];
            r_rd_vb <= r_vb[i_req.rd_idx];
        end
    end

    // Entry never written since reset or reset-all reads as zero; timer, since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
        end else begin
            if (i_req.clr_a) begin
                r_va <= '0;
            end else if (i_req.wr_a_en) begin
                r_va[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.wr_b_en) begin
                r_vb[i_req.wr_idx] <= 1'b1;
            end
        end
    end

    assign o_rd.a = r_rd_va ? r_rd_a : '0;
    assign o_rd.b = r_rd_vb ? r_rd_b : '0;

endmodule
`default_nettype wire

[design/heartbeat_node_monitor_top.sv]
// Heartbeat node monitor top level: sequencer, config registers, result register.
//
// Input channel: i_in_valid / o_in_stall / i_in_word, one command word each.
// Output channel: o_out_valid / i_out_stall / o_out_word, one word for each
// check-ready or check-operational command, none for the other commands.
// Config: APB-style port, guard_reload at 0x0, first_node at 0x4, pready tied high.
// Items are processed one at a time; the table sequencer issues one memory read
// per cycle, write-back in the cycle after the read.
//   heartbeat: accept, read, write back.
//   tick, clear boot flags: accept, 15 entry reads, drain.
//   checks: accept, entry reads from first_node to the last, drain, then the
//   result register, then the word is offered; first_node of 15 gives all good.
//   reset all, unused commands, heartbeat to nibble 0: accept only.
// o_in_stall is high while an item is in the sequencer; the result register
// lets the next item start while a word waits. A check that finishes while a
// word is still stalled waits for it before loading its own.
// Reset: guard_reload 5000, first_node 0, all table entries read as zero,
// no word pending. Alarm code of the last check stays in the result register.
`default_nettype none
module heartbeat_node_monitor_top
    import hbm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    t_state r_state, n_state;

    logic [TIMER_W-1:0] r_guard_reload;
    logic [IDX_W-1:0]   r_first_node;

    logic [2:0]         r_cmd;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [STATE_W-1:0] r_hb_state;
    logic               r_wb_vld;
    logic [IDX_W-1:0]   r_wb_idx;

    logic               r_fail;
    logic [ALARM_W-1:0] r_code;
    logic [IDX_W-1:0]   r_where;

    logic               r_ovld;
    t_out_word          r_out;

    logic               in_acc;
    logic               out_acc;
    logic               cfg_wr;
    logic               hb_ok;
    logic               issue;
    logic               load_out;
    logic [ALARM_W-1:0] code;

    t_tbl_req tbl_req;
    t_tbl_rd  tbl_rd;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_ovld && !i_out_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign hb_ok   = (i_in_word.node_nibble != 4'd0) &&
                     ({1'b0, i_in_word.node_nibble} <= 5'(NUM_NODES));

    assign pready = 1'b1;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_reload <= 16'd5000;
            r_first_node   <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_GUARD_RELOAD: r_guard_reload <= pwdata[TIMER_W-1:0];
                REG_FIRST_NODE:   r_first_node   <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GUARD_RELOAD: prdata = {16'd0, r_guard_reload};
            REG_FIRST_NODE:   prdata = {28'd0, r_first_node};
            default:          prdata = '0;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        issue      = 1'b0;
        load_out   = 1'b0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.command)
                        CMD_HEARTBEAT: begin
                            n_idx = i_in_word.node_nibble - 4'd1;
                            if (hb_ok) begin
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_TICK, CMD_CLEAR_BOOT: begin
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        CMD_READY, CMD_OPER: begin
                            n_idx = r_first_node;
                            if ({1'b0, r_first_node} < 5'(NUM_NODES)) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_FIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                issue = 1'b1;
                if ((r_cmd == CMD_HEARTBEAT) || (r_idx == LAST_IDX)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            ST_DRAIN: begin
                if ((r_cmd == CMD_READY) || (r_cmd == CMD_OPER)) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (!r_ovld || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Per-node alarm from the entry in the write-back stage
    always_comb begin
        code = ALM_OK;
        if (r_cmd == CMD_OPER) begin
            if (tbl_rd.a.state != STATE_OPER) begin
                code = ALM_NOT_OPER;
            end else if (tbl_rd.b == '0) begin
                code = ALM_TIMEOUT;
            end
        end else begin
            if (!tbl_rd.a.booted) begin
                code = ALM_BOOT;
            end else if ((tbl_rd.a.state != STATE_PREOP) &&
                         (tbl_rd.a.state != STATE_OPER)) begin
                code = ALM_NOT_READY;
            end
        end
    end

    // Table requests: read issued in SCAN, write-back in the following cycle
    always_comb begin
        tbl_req         = '0;
        tbl_req.rd_en   = issue;
        tbl_req.rd_idx  = r_idx;
        tbl_req.wr_idx  = r_wb_idx;
        tbl_req.wr_a    = tbl_rd.a;
        tbl_req.wr_b    = tbl_rd.b;
        tbl_req.clr_a   = in_acc && (i_in_word.command == CMD_RESET_ALL);
        if (r_wb_vld) begin
            case (r_cmd)
                CMD_HEARTBEAT: begin
                    tbl_req.wr_a.state  = r_hb_state;
                    tbl_req.wr_a.booted = tbl_rd.a.booted || (r_hb_state == '0);
                    tbl_req.wr_b        = r_guard_reload;
                    tbl_req.wr_a_en     = 1'b1;
                    tbl_req.wr_b_en     = 1'b1;
                end
                CMD_TICK: begin
                    if (tbl_rd.b != '0) begin
                        tbl_req.wr_b = tbl_rd.b - 16'd1;
                    end
                    tbl_req.wr_b_en = 1'b1;
                end
                CMD_READY, CMD_OPER: begin
                    tbl_req.wr_a.alarm = code;
                    tbl_req.wr_a_en    = 1'b1;
                end
                CMD_CLEAR_BOOT: begin
                    tbl_req.wr_a.booted = 1'b0;
                    tbl_req.wr_a_en     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wb_idx <= r_idx;
        if (in_acc) begin
            r_cmd      <= i_in_word.command;
            r_hb_state <= i_in_word.heartbeat_byte[STATE_W-1:0];
            r_code     <= ALM_OK;
            r_where    <= '0;
        end else if (r_wb_vld && !r_fail && (code != ALM_OK) &&
                     ((r_cmd == CMD_READY) || (r_cmd == CMD_OPER))) begin
            r_code  <= code;
            r_where <= r_wb_idx;
        end
        // r_out.alarm_code doubles as the current alarm after a check
        if (load_out) begin
            r_out.all_good   <= !r_fail;
            r_out.alarm_code <= r_code;
            r_out.alarm_node <= r_where;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
            r_fail   <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_wb_vld <= issue;
            if (in_acc) begin
                r_fail <= 1'b0;
            end else if (r_wb_vld && (code != ALM_OK) &&
                         ((r_cmd == CMD_READY) || (r_cmd == CMD_OPER))) begin
                r_fail <= 1'b1;
            end
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (out_acc) begin
                r_ovld <= 1'b0;
            end
        end
    end

    hbm_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rd    (tbl_rd)
    );

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

[design/hbm_checker.sv]
// Port-level checker for the heartbeat node monitor, bound to the top level.
`default_nettype none
`include "heartbeat_node_monitor_top_assert.svh"
module hbm_checker
    import hbm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    logic out_held;
    logic tick_acc;
    logic good_word;
    logic clean_word;

    assign out_held   = o_out_valid && i_out_stall;
    assign tick_acc   = i_in_valid && !o_in_stall && (i_in_word.command == CMD_TICK);
    assign good_word  = o_out_valid && o_out_word.all_good;
    assign clean_word = (o_out_word.alarm_code == ALM_OK) && (o_out_word.alarm_node == 4'd0);

    `HBM_ASSERT_NEXT(a_out_hold, out_held, o_out_valid, "out word dropped while stalled")
    `HBM_ASSERT_NEXT(a_out_stable, out_held, $stable(o_out_word), "stalled out word changed")
    `HBM_ASSERT_NEXT(a_tick_busy, tick_acc, o_in_stall, "tick did not start a table sweep")
    `HBM_ASSERT_NOW(a_good_clean, good_word, clean_word, "all good word carries an alarm")

endmodule

bind heartbeat_node_monitor_top hbm_checker u_hbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire
